// ===== hdl/mer_pkg.sv =====
// shared types and constants of the midpoint ellipse rasterizer
// no dependencies; used by the interfaces, the controller, the datapath and the top level
`default_nettype none

package mer_pkg;

   localparam int AXIS_BITS_DEF  = 10;
   localparam int COORD_BITS_DEF = 12;

   // request kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_SQ_A,
      CMD_SQ_B,
      CMD_MUL_AB,
      CMD_INIT,
      CMD_TT,
      CMD_BT,
      CMD_UU,
      CMD_AU,
      CMD_ABSQ,
      CMD_ENTER,
      CMD_EMIT
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type cmd;
   } ctl_type;

   typedef struct packed {
      logic region_one;    // 2*b^2*x < 2*a^2*y still holds
      logic region_two;
      logic final_point;   // the pending emit ends the ellipse
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/mer_channels.sv =====
// request and response channel interfaces of the ellipse rasterizer
// depends on mer_pkg for default widths
`default_nettype none

interface mer_req_if #(
   parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
   parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic        [AXIS_BITS-1:0]  semi_axis_x;
   logic        [AXIS_BITS-1:0]  semi_axis_y;

   modport source (output valid, req_type, center_x, center_y, semi_axis_x, semi_axis_y,
                   input ready);
   modport sink   (input valid, req_type, center_x, center_y, semi_axis_x, semi_axis_y,
                   output ready);
endinterface

interface mer_rsp_if #(
   parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic signed [COORD_BITS:0] x_right;
   logic signed [COORD_BITS:0] x_left;
   logic signed [COORD_BITS:0] y_below;
   logic signed [COORD_BITS:0] y_above;
   logic                       last;

   modport source (output valid, x_right, x_left, y_below, y_above, last, input ready);
   modport sink   (input valid, x_right, x_left, y_below, y_above, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/mer_ctrl.sv =====
// controller of the ellipse rasterizer: sequences start, region entry and emit
// depends on mer_pkg; drives the datapath through ctl_type, reads status_type
`default_nettype none

module mer_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_type,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output mer_pkg::ctl_type        ctl,
   input  wire mer_pkg::status_type status
);
   import mer_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_A,
      ST_SQ_B,
      ST_AB,
      ST_INIT,
      ST_TT,
      ST_BT,
      ST_UU,
      ST_AU,
      ST_ABSQ,
      ST_ENTER,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;
   logic      emit_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl.cmd      = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_type == REQ_START) begin
                  ctl.cmd  = CMD_CAPTURE;
                  state_in = ST_SQ_A;
               end else if (busy_ff) begin
                  if (!status.region_two && !status.region_one) begin
                     state_in = ST_TT;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_SQ_A: begin
            ctl.cmd  = CMD_SQ_A;
            state_in = ST_SQ_B;
         end
         ST_SQ_B: begin
            ctl.cmd  = CMD_SQ_B;
            state_in = ST_AB;
         end
         ST_AB: begin
            ctl.cmd  = CMD_MUL_AB;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            ctl.cmd  = CMD_INIT;
            busy_in  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_TT: begin
            ctl.cmd  = CMD_TT;
            state_in = ST_BT;
         end
         ST_BT: begin
            ctl.cmd  = CMD_BT;
            state_in = ST_UU;
         end
         ST_UU: begin
            ctl.cmd  = CMD_UU;
            state_in = ST_AU;
         end
         ST_AU: begin
            ctl.cmd  = CMD_AU;
            state_in = ST_ABSQ;
         end
         ST_ABSQ: begin
            ctl.cmd  = CMD_ABSQ;
            state_in = ST_ENTER;
         end
         ST_ENTER: begin
            ctl.cmd  = CMD_ENTER;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // wait here while the previous response is still held
            if (emit_fire) begin
               ctl.cmd      = CMD_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (status.final_point) begin
                  busy_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a new point set never overwrites one that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.cmd == CMD_EMIT |-> (!rsp_valid_ff || rsp_ready))
      else $error("emit while response still pending");

   a_final_ends: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_EMIT && status.final_point) |=> (!busy_ff && rsp_valid_ff))
      else $error("final point set did not end the ellipse");

   a_entry_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TT |-> (busy_ff && !status.region_two))
      else $error("region two entry without an active region one");

   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_type == REQ_STEP && !busy_ff) |=> (state_ff == ST_IDLE && !busy_ff))
      else $error("step while idle changed the controller");

endmodule

`default_nettype wire

// ===== hdl/mer_datapath.sv =====
// datapath of the ellipse rasterizer: shared multiplier, decision and offset update
// depends on mer_pkg; commanded by mer_ctrl
`default_nettype none

module mer_datapath #(
   parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
   parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire mer_pkg::ctl_type             ctl,
   output mer_pkg::status_type               status,
   input  wire logic signed [COORD_BITS-1:0] center_x,
   input  wire logic signed [COORD_BITS-1:0] center_y,
   input  wire logic        [AXIS_BITS-1:0]  semi_axis_x,
   input  wire logic        [AXIS_BITS-1:0]  semi_axis_y,
   output logic signed [COORD_BITS:0]        x_right,
   output logic signed [COORD_BITS:0]        x_left,
   output logic signed [COORD_BITS:0]        y_below,
   output logic signed [COORD_BITS:0]        y_above,
   output logic                              last
);
   import mer_pkg::*;

   localparam int SQW  = 2 * AXIS_BITS;          // a^2, b^2
   localparam int OW   = 2 * AXIS_BITS + 4;      // multiplier operand
   localparam int PRW  = 2 * OW;                 // multiplier product
   localparam int DW   = 4 * AXIS_BITS + 6;      // decision and accumulator
   localparam int PW   = 3 * AXIS_BITS + 4;      // 2*b^2*x and 2*a^2*y
   localparam int XW   = AXIS_BITS + 2;
   localparam int YW   = AXIS_BITS + 2;
   localparam int OUTW = COORD_BITS + 1;
   localparam int EW   = ((COORD_BITS > YW) ? COORD_BITS : YW) + 1;

   logic signed [COORD_BITS-1:0] cx_ff, cy_ff;
   logic        [AXIS_BITS-1:0]  a_ff, b_ff;
   logic        [SQW-1:0]        asq_ff, bsq_ff;
   logic        [XW-1:0]         x_ff;
   logic signed [YW-1:0]         y_ff;
   logic signed [PW-1:0]         px_ff, py_ff;
   logic signed [DW-1:0]         d_ff;
   logic signed [DW-1:0]         acc_ff;
   logic        [PRW-1:0]        prod_ff;
   logic                         r2_ff;
   logic signed [OUTW-1:0]       xr_ff, xl_ff, yb_ff, ya_ff;
   logic                         last_ff;

   // multiplier operands
   logic [OW-1:0]  op_a, op_b;
   logic [OW-1:0]  t_val, u_abs;
   logic [YW-1:0]  y_m1;
   logic           mul_en;

   // step update
   logic                 x_inc, y_dec, d_pos;
   logic signed [PW-1:0] bsq2, asq2, px_n, py_n;
   logic signed [DW-1:0] d_n, add_sq;
   logic [XW-1:0]        x_n;
   logic signed [YW-1:0] y_n;
   logic signed [DW-1:0] prod4, q_val, q_div;

   // output coordinates
   logic signed [EW-1:0] cx_e, cy_e, x_e, y_e;
   logic signed [EW-1:0] xr_e, xl_e, yb_e, ya_e;

   assign t_val = OW'({x_ff, 1'b1});
   assign y_m1  = y_ff - YW'(1);
   // y is never negative on region two entry, so |y-1| only needs y == 0 special
   assign u_abs = (y_ff == '0) ? OW'(1) : OW'(y_m1);

   always_comb begin
      op_a   = '0;
      op_b   = '0;
      mul_en = 1'b1;
      case (ctl.cmd)
         CMD_SQ_A: begin
            op_a = OW'(a_ff);
            op_b = OW'(a_ff);
         end
         CMD_SQ_B: begin
            op_a = OW'(b_ff);
            op_b = OW'(b_ff);
         end
         CMD_MUL_AB: begin
            op_a = OW'(asq_ff);
            op_b = OW'(b_ff);
         end
         CMD_TT: begin
            op_a = t_val;
            op_b = t_val;
         end
         CMD_BT: begin
            op_a = OW'(bsq_ff);
            op_b = prod_ff[OW-1:0];
         end
         CMD_UU: begin
            op_a = u_abs;
            op_b = u_abs;
         end
         CMD_AU: begin
            op_a = OW'(asq_ff);
            op_b = prod_ff[OW-1:0];
         end
         CMD_ABSQ: begin
            op_a = OW'(asq_ff);
            op_b = OW'(bsq_ff);
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign bsq2 = $signed(PW'({bsq_ff, 1'b0}));
   assign asq2 = $signed(PW'({asq_ff, 1'b0}));
   assign d_pos = (d_ff > 0);

   always_comb begin
      if (!r2_ff) begin
         x_inc = 1'b1;
         y_dec = d_pos;
      end else begin
         y_dec = 1'b1;
         x_inc = !d_pos;
      end
   end

   assign px_n   = x_inc ? (px_ff + bsq2) : px_ff;
   assign py_n   = y_dec ? (py_ff - asq2) : py_ff;
   assign x_n    = x_inc ? (x_ff + XW'(1)) : x_ff;
   assign y_n    = y_dec ? (y_ff - YW'(1)) : y_ff;
   assign add_sq = r2_ff ? $signed(DW'(asq_ff)) : $signed(DW'(bsq_ff));
   assign d_n    = d_ff
                 + (x_inc ? {{(DW-PW){px_n[PW-1]}}, px_n} : '0)
                 - (y_dec ? {{(DW-PW){py_n[PW-1]}}, py_n} : '0)
                 + add_sq;

   // region two start value: quarter units truncated toward zero
   assign prod4 = $signed({prod_ff[DW-3:0], 2'b00});
   assign q_val = acc_ff - prod4;
   assign q_div = (q_val >>> 2)
                + $signed(DW'(q_val[DW-1] && (q_val[1:0] != 2'b00)));

   always_ff @(posedge clock) begin
      if (mul_en) begin
         // operands carry only OW significant bits
         prod_ff <= PRW'(op_a) * PRW'(op_b);
      end
      case (ctl.cmd)
         CMD_CAPTURE: begin
            cx_ff <= center_x;
            cy_ff <= center_y;
            a_ff  <= semi_axis_x;
            b_ff  <= semi_axis_y;
            x_ff  <= '0;
            y_ff  <= $signed(YW'(semi_axis_y));
            px_ff <= '0;
         end
         CMD_SQ_B: begin
            asq_ff <= prod_ff[SQW-1:0];
         end
         CMD_MUL_AB: begin
            bsq_ff <= prod_ff[SQW-1:0];
         end
         CMD_INIT: begin
            d_ff  <= $signed(DW'(bsq_ff)) - $signed(prod_ff[DW-1:0])
                   + $signed(DW'(asq_ff[SQW-1:2]));
            py_ff <= $signed({prod_ff[PW-2:0], 1'b0});
         end
         CMD_UU: begin
            acc_ff <= $signed(prod_ff[DW-1:0]);
         end
         CMD_ABSQ: begin
            acc_ff <= acc_ff + prod4;
         end
         CMD_ENTER: begin
            d_ff <= q_div;
         end
         CMD_EMIT: begin
            x_ff    <= x_n;
            y_ff    <= y_n;
            px_ff   <= px_n;
            py_ff   <= py_n;
            d_ff    <= d_n;
            xr_ff   <= xr_e[OUTW-1:0];
            xl_ff   <= xl_e[OUTW-1:0];
            yb_ff   <= yb_e[OUTW-1:0];
            ya_ff   <= ya_e[OUTW-1:0];
            last_ff <= r2_ff && y_n[YW-1];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_ff <= 1'b0;
      end else if (ctl.cmd == CMD_CAPTURE) begin
         r2_ff <= 1'b0;
      end else if (ctl.cmd == CMD_ENTER) begin
         r2_ff <= 1'b1;
      end
   end

   // coordinates wrap to the output width
   assign cx_e = {{(EW-COORD_BITS){cx_ff[COORD_BITS-1]}}, cx_ff};
   assign cy_e = {{(EW-COORD_BITS){cy_ff[COORD_BITS-1]}}, cy_ff};
   assign x_e  = $signed(EW'(x_ff));
   assign y_e  = {{(EW-YW){y_ff[YW-1]}}, y_ff};
   assign xr_e = cx_e + x_e;
   assign xl_e = cx_e - x_e;
   assign yb_e = cy_e + y_e;
   assign ya_e = cy_e - y_e;

   assign status.region_one  = (px_ff < py_ff);
   assign status.region_two  = r2_ff;
   assign status.final_point = r2_ff && y_n[YW-1];

   assign x_right = xr_ff;
   assign x_left  = xl_ff;
   assign y_below = yb_ff;
   assign y_above = ya_ff;
   assign last    = last_ff;

endmodule

`default_nettype wire

// ===== hdl/midpoint_ellipse_rasterizer_core.sv =====
// top level of the midpoint ellipse rasterizer
// depends on mer_pkg, mer_channels (mer_req_if, mer_rsp_if), mer_ctrl and mer_datapath
//
//   channel   direction  handshake          payload
//   req_bus   in         valid/ready        req_type, center_x, center_y, semi_axis_x/y
//   rsp_bus   out        valid/ready        x_right, x_left, y_below, y_above, last
//
// a step request is accepted, then the decision and offset update go into the
// response register; the first step of region two first runs TT, BT, UU, AU and
// ABSQ on the shared multiplier, then ENTER. a start: three multiplies, decision load.
// reset clears the controller and region flag; there is no clearing pass.
// a stalled response holds the next point set in its update state; requests are
// still taken while a response waits.
`default_nettype none

module midpoint_ellipse_rasterizer_core #(
   parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
   parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   mer_req_if.sink   req_bus,
   mer_rsp_if.source rsp_bus
);
   import mer_pkg::*;

   ctl_type    ctl;
   status_type status;

   mer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.req_type),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctl       (ctl),
      .status    (status)
   );

   mer_datapath #(
      .AXIS_BITS  (AXIS_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .status      (status),
      .center_x    (req_bus.center_x),
      .center_y    (req_bus.center_y),
      .semi_axis_x (req_bus.semi_axis_x),
      .semi_axis_y (req_bus.semi_axis_y),
      .x_right     (rsp_bus.x_right),
      .x_left      (rsp_bus.x_left),
      .y_below     (rsp_bus.y_below),
      .y_above     (rsp_bus.y_above),
      .last        (rsp_bus.last)
   );

endmodule

`default_nettype wire
